/* rtl/atp_pkg.sv */
// Package with the shared constants, types and state codes of the attribute tolerance pruner.
package atp_pkg;

    localparam int NUM_ATTRS = 64;
    localparam int IDX_W     = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
    localparam int CNT_W     = $clog2(NUM_ATTRS + 1);
    localparam int VAL_W     = 32;
    localparam int ERR_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * VAL_W;

    localparam logic [ERR_W-1:0] ONE_Q16  = ERR_W'(1) << FRAC_W;
    localparam logic [ERR_W-1:0] ERR_MAX  = {ERR_W{1'b1}};
    localparam logic [VAL_W-1:0] SIGN_BIT = VAL_W'(1) << (VAL_W - 1);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_APPLY = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] ref_val;
        logic             cat;
        logic [ERR_W-1:0] limit;
        logic [ERR_W-1:0] err;
    } t_entry;

    typedef struct packed {
        logic diff_en;
        logic mul_en;
    } t_pen_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_UPD
    } t_state;

endpackage

/* rtl/atp_entry_ram.sv */
// Entry memory: one synchronous write port and one registered read port.
module atp_entry_ram (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [atp_pkg::IDX_W-1:0] i_waddr,
    input  atp_pkg::t_entry        i_wdata,
    input  logic [atp_pkg::IDX_W-1:0] i_raddr,
    output atp_pkg::t_entry        o_rdata
);

    atp_pkg::t_entry r_mem [atp_pkg::NUM_ATTRS];
    atp_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/atp_penalty.sv */
// Two-stage penalty unit: magnitude of the difference, then the square or the mismatch penalty.
module atp_penalty (
    input  logic                      i_clk,
    input  atp_pkg::t_pen_ctrl        i_ctrl,
    input  logic [atp_pkg::VAL_W-1:0] i_ref,
    input  logic                      i_cat,
    input  logic [atp_pkg::VAL_W-1:0] i_val,
    output logic [atp_pkg::ERR_W-1:0] o_penalty
);

    logic [atp_pkg::VAL_W-1:0]  n_mag;
    logic [atp_pkg::VAL_W-1:0]  a_off;
    logic [atp_pkg::VAL_W-1:0]  b_off;
    logic [atp_pkg::VAL_W-1:0]  r_mag;
    logic                       r_mismatch;
    logic                       r_cat;
    logic [atp_pkg::PROD_W-1:0] n_prod;
    logic [atp_pkg::ERR_W-1:0]  n_penalty;
    logic [atp_pkg::ERR_W-1:0]  r_penalty;

    // Offset-binary forms turn the signed difference into an unsigned compare.
    always_comb begin
        a_off = i_val ^ atp_pkg::SIGN_BIT;
        b_off = i_ref ^ atp_pkg::SIGN_BIT;
        n_mag = (a_off >= b_off) ? (a_off - b_off) : (b_off - a_off);
    end

    always_comb begin
        n_prod = r_mag * r_mag;
        if (r_cat) begin
            n_penalty = r_mismatch ? atp_pkg::ONE_Q16 : '0;
        end else begin
            n_penalty = n_prod[atp_pkg::PROD_W-1:atp_pkg::FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.diff_en) begin
            r_mag      <= n_mag;
            r_mismatch <= (i_ref != i_val);
            r_cat      <= i_cat;
        end
        if (i_ctrl.mul_en) begin
            r_penalty <= n_penalty;
        end
    end

    assign o_penalty = r_penalty;

endmodule

/* rtl/attribute_tolerance_pruner.sv */
// Top level of the attribute tolerance pruner: control, alive marks, update and result register.
//
// The block takes a new item only in its idle state. An accepted item reads its table entry
// from the entry memory in the cycle it is accepted, forms the difference magnitude in the
// DIFF state, squares it in the MUL state and in the UPD state adds the penalty with
// saturation, compares against the limit, writes the entry back and loads the result
// register. That read, difference, square and write-back sequence through the entry memory
// sets the rate; only one item is in flight, so no forwarding between items is needed.
// A result waiting in the output register does not stop the next item from being accepted;
// that item only holds in its last step until the result register is free. The alive marks
// are flip-flops cleared by reset, so there is no clearing pass and the block is ready right
// after reset. The other entry fields are undefined until an entry is loaded, and they are
// only ever used for live entries. Items whose index lies outside the table leave the table
// alone and still report survivors and the end-of-instance shrink mark.
module attribute_tolerance_pruner (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic [5:0]                i_attr_index,
    input  logic signed [31:0]        i_value,
    input  logic                      i_is_categorical,
    input  logic [47:0]               i_error_limit,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [5:0]                o_entry_index,
    output logic                      o_alive,
    output logic [47:0]               o_accumulated_error,
    output logic [6:0]                o_survivors,
    output logic                      o_shrank,
    output logic                      o_last_res
);

    atp_pkg::t_state r_state;
    atp_pkg::t_state n_state;

    // Captured item.
    logic                          r_kind;
    logic [5:0]                    r_idx;
    logic [atp_pkg::VAL_W-1:0]     r_val;
    logic                          r_cat;
    logic [atp_pkg::ERR_W-1:0]     r_lim;
    logic                          r_last;

    // Table-wide state.
    logic [atp_pkg::NUM_ATTRS-1:0] r_alive;
    logic [atp_pkg::NUM_ATTRS-1:0] n_alive;
    logic [atp_pkg::CNT_W-1:0]     r_live_count;
    logic [atp_pkg::CNT_W-1:0]     n_live_count;
    logic                          r_dropped;
    logic                          n_dropped;

    // Result register.
    logic                          r_out_valid;
    logic [5:0]                    r_out_idx;
    logic                          r_out_alive;
    logic [atp_pkg::ERR_W-1:0]     r_out_err;
    logic [atp_pkg::CNT_W-1:0]     r_out_count;
    logic                          r_out_shrank;
    logic                          r_out_last;

    logic                          n_out_alive;
    logic [atp_pkg::ERR_W-1:0]     n_out_err;
    logic                          n_out_shrank;

    // FSM outputs.
    logic                          in_take;
    logic                          upd_done;
    atp_pkg::t_pen_ctrl            pen_ctrl;

    // Memory and datapath.
    logic [atp_pkg::IDX_W-1:0]     raddr;
    logic [atp_pkg::IDX_W-1:0]     addr;
    atp_pkg::t_entry               rdata;
    atp_pkg::t_entry               wdata;
    logic                          we;
    logic [atp_pkg::ERR_W-1:0]     penalty;
    logic [atp_pkg::ERR_W:0]       sum;
    logic [atp_pkg::ERR_W-1:0]     new_err;
    logic                          in_range;
    logic                          alive_old;
    logic                          drop;

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            atp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = atp_pkg::ST_DIFF;
                end
            end
            atp_pkg::ST_DIFF: n_state = atp_pkg::ST_MUL;
            atp_pkg::ST_MUL:  n_state = atp_pkg::ST_UPD;
            atp_pkg::ST_UPD: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = atp_pkg::ST_IDLE;
                end
            end
            default: n_state = atp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall          = 1'b1;
        in_take          = 1'b0;
        upd_done         = 1'b0;
        pen_ctrl.diff_en = 1'b0;
        pen_ctrl.mul_en  = 1'b0;
        case (r_state)
            atp_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                in_take = i_valid;
            end
            atp_pkg::ST_DIFF: pen_ctrl.diff_en = 1'b1;
            atp_pkg::ST_MUL:  pen_ctrl.mul_en  = 1'b1;
            atp_pkg::ST_UPD:  upd_done = !r_out_valid || !i_stall;
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_idx  <= i_attr_index;
            r_val  <= i_value;
            r_cat  <= i_is_categorical;
            r_lim  <= i_error_limit;
            r_last <= i_last;
        end
    end

    // ---------------------------------------------------------------- memory
    // The entry is read in the accept cycle so its data is ready in the DIFF state.
    assign raddr = (r_state == atp_pkg::ST_IDLE) ? atp_pkg::IDX_W'(i_attr_index)
                                                 : atp_pkg::IDX_W'(r_idx);
    assign addr  = atp_pkg::IDX_W'(r_idx);

    atp_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    atp_penalty u_pen (
        .i_clk     (i_clk),
        .i_ctrl    (pen_ctrl),
        .i_ref     (rdata.ref_val),
        .i_cat     (rdata.cat),
        .i_val     (r_val),
        .o_penalty (penalty)
    );

    // ---------------------------------------------------------------- update
    always_comb begin
        in_range  = 32'(r_idx) < 32'(atp_pkg::NUM_ATTRS);
        alive_old = r_alive[addr];

        // Saturating add of the penalty to the stored error.
        sum     = {1'b0, rdata.err} + {1'b0, penalty};
        new_err = sum[atp_pkg::ERR_W] ? atp_pkg::ERR_MAX : sum[atp_pkg::ERR_W-1:0];

        drop = in_range && (r_kind == atp_pkg::KIND_APPLY) && alive_old
               && (new_err > rdata.limit);

        we           = 1'b0;
        wdata        = rdata;
        n_alive      = r_alive;
        n_live_count = r_live_count;
        n_out_alive  = 1'b0;
        n_out_err    = '0;

        if (in_range) begin
            if (r_kind == atp_pkg::KIND_LOAD) begin
                we            = upd_done;
                wdata.ref_val = r_val;
                wdata.cat     = r_cat;
                wdata.limit   = r_lim;
                wdata.err     = '0;
                n_alive[addr] = 1'b1;
                n_out_alive   = 1'b1;
                if (!alive_old) begin
                    n_live_count = r_live_count + atp_pkg::CNT_W'(1);
                end
            end else if (alive_old) begin
                we          = upd_done;
                wdata.err   = new_err;
                n_out_err   = new_err;
                n_out_alive = !drop;
                if (drop) begin
                    n_alive[addr] = 1'b0;
                    n_live_count  = r_live_count - atp_pkg::CNT_W'(1);
                end
            end
        end

        // The shrink mark gathers drops until the end of an instance, which reports and clears it.
        n_out_shrank = r_last && (r_dropped || drop);
        n_dropped    = r_last ? 1'b0 : (r_dropped || drop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive      <= '0;
            r_live_count <= '0;
            r_dropped    <= 1'b0;
        end else if (upd_done) begin
            r_alive      <= n_alive;
            r_live_count <= n_live_count;
            r_dropped    <= n_dropped;
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_done) begin
            r_out_idx    <= r_idx;
            r_out_alive  <= n_out_alive;
            r_out_err    <= n_out_err;
            r_out_count  <= n_live_count;
            r_out_shrank <= n_out_shrank;
            r_out_last   <= r_last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_entry_index       = r_out_idx;
    assign o_alive             = r_out_alive;
    assign o_accumulated_error = r_out_err;
    assign o_survivors         = 7'(r_out_count);
    assign o_shrank            = r_out_shrank;
    assign o_last_res          = r_out_last;

    // ---------------------------------------------------------------- checks
    // The live count always matches the number of set alive marks.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_alive)) == 32'(r_live_count))
        else $error("live count differs from the alive marks");

    // An accepted item reaches its update step after passing through the DIFF and MUL states.
    a_upd_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |-> ##3 (r_state == atp_pkg::ST_UPD))
        else $error("item did not reach the update step on time");

    // A shrink report only appears on the final value of an instance.
    a_shrank_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_shrank) |-> r_out_last)
        else $error("shrink reported without the last mark");

    // A waiting result that says alive matches the entry's current alive mark.
    a_alive_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_alive) |-> r_alive[atp_pkg::IDX_W'(r_out_idx)])
        else $error("result says alive but the entry is dropped");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the attribute tolerance pruner: stimulus queue, driver, monitor, predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Roughly how many items the run offers, and the stretch lengths used for pacing.
    localparam int ITEM_COUNT    = 1250;
    localparam int IDLE_HEAVY    = 59;
    localparam int IDLE_LIGHT    = 16;
    localparam int HOLD_OFF_AT   = 100;
    localparam int HOLD_OFF_LEN  = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 40;

    // One item as offered on the input channel.
    typedef struct packed {
        logic                      kind;
        logic [atp_pkg::IDX_W-1:0] attr_index;
        logic [atp_pkg::VAL_W-1:0] value;
        logic                      is_cat;
        logic [atp_pkg::ERR_W-1:0] error_limit;
        logic                      last;
    } t_pruner_item;

    // One item as it should appear on the result channel.
    typedef struct packed {
        logic [atp_pkg::IDX_W-1:0] entry_index;
        logic                      alive;
        logic [atp_pkg::ERR_W-1:0] accumulated_error;
        logic [atp_pkg::CNT_W-1:0] survivors;
        logic                      shrank;
        logic                      last_res;
    } t_pruner_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_kind = atp_pkg::KIND_LOAD;
    logic [5:0]           i_attr_index = '0;
    logic signed [31:0]   i_value = '0;
    logic                 i_is_categorical = 1'b0;
    logic [47:0]          i_error_limit = '0;
    logic                 i_last = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [5:0]           o_entry_index;
    logic                 o_alive;
    logic [47:0]          o_accumulated_error;
    logic [6:0]           o_survivors;
    logic                 o_shrank;
    logic                 o_last_res;

    attribute_tolerance_pruner uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_kind              (i_kind),
        .i_attr_index        (i_attr_index),
        .i_value             (i_value),
        .i_is_categorical    (i_is_categorical),
        .i_error_limit       (i_error_limit),
        .i_last              (i_last),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_entry_index       (o_entry_index),
        .o_alive             (o_alive),
        .o_accumulated_error (o_accumulated_error),
        .o_survivors         (o_survivors),
        .o_shrank            (o_shrank),
        .o_last_res          (o_last_res)
    );

    // Items waiting to be offered, and the results predicted for accepted items.
    t_pruner_item   pending_items[$];
    t_pruner_result expected_results[$];
    t_pruner_item   offered;

    int total_items = 1;
    int sent_count = 0;
    int recv_count = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // The predictor's own copy of the entry table and the instance bookkeeping.
    logic [atp_pkg::VAL_W-1:0] ref_copy [atp_pkg::NUM_ATTRS];
    logic                      cat_copy [atp_pkg::NUM_ATTRS];
    logic [atp_pkg::ERR_W-1:0] limit_copy [atp_pkg::NUM_ATTRS];
    logic [atp_pkg::ERR_W-1:0] error_copy [atp_pkg::NUM_ATTRS];
    logic                      live_copy [atp_pkg::NUM_ATTRS];
    logic [atp_pkg::CNT_W-1:0] live_total = '0;
    logic                      drop_seen = 1'b0;

    initial begin
        foreach (live_copy[k]) live_copy[k] = 1'b0;
    end

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one accepted item to the predicted table and returns the result it must produce.
    // A categorical entry costs 1.0 on any mismatch of the full 32 bits. A numeric entry costs
    // the square of the exact 33-bit difference, truncated from Q32.32 to Q32.16. The sum
    // saturates at the largest 48-bit error, and the entry dies only when the error is strictly
    // above its limit, so a saturated error against an all-ones limit keeps the entry alive.
    function automatic t_pruner_result prune_step(input t_pruner_item it);
        t_pruner_result            r;
        logic signed [32:0]        diff;
        logic [31:0]               mag;
        logic [63:0]               square;
        logic [atp_pkg::ERR_W-1:0] pen;
        logic [atp_pkg::ERR_W:0]   sum;
        r = '0;
        r.entry_index = it.attr_index;
        r.last_res = it.last;
        if (it.attr_index < atp_pkg::NUM_ATTRS) begin
            if (it.kind == atp_pkg::KIND_LOAD) begin
                if (!live_copy[it.attr_index]) live_total = live_total + 1'b1;
                ref_copy[it.attr_index]   = it.value;
                cat_copy[it.attr_index]   = it.is_cat;
                limit_copy[it.attr_index] = it.error_limit;
                error_copy[it.attr_index] = '0;
                live_copy[it.attr_index]  = 1'b1;
                r.alive = 1'b1;
            end else if (live_copy[it.attr_index]) begin
                if (cat_copy[it.attr_index]) begin
                    pen = (ref_copy[it.attr_index] == it.value) ? '0 : atp_pkg::ONE_Q16;
                end else begin
                    diff = $signed({it.value[atp_pkg::VAL_W-1], it.value})
                         - $signed({ref_copy[it.attr_index][atp_pkg::VAL_W-1],
                                    ref_copy[it.attr_index]});
                    mag = diff[32] ? 32'(-diff) : diff[31:0];
                    square = 64'(mag) * 64'(mag);
                    pen = square[63:16];
                end
                sum = {1'b0, error_copy[it.attr_index]} + {1'b0, pen};
                error_copy[it.attr_index] = sum[atp_pkg::ERR_W] ? atp_pkg::ERR_MAX
                                                                : sum[atp_pkg::ERR_W-1:0];
                r.accumulated_error = error_copy[it.attr_index];
                if (error_copy[it.attr_index] > limit_copy[it.attr_index]) begin
                    live_copy[it.attr_index] = 1'b0;
                    if (live_total != 0) live_total = live_total - 1'b1;
                    drop_seen = 1'b1;
                end else begin
                    r.alive = 1'b1;
                end
            end
        end
        if (it.last) begin
            r.shrank = drop_seen;
            drop_seen = 1'b0;
        end
        r.survivors = live_total;
        return r;
    endfunction

    // The run is split into five equal stretches by item count: no idling, sender gaps,
    // receiver stalls, both together, and a closing stretch with no idling again.
    function automatic int idle_pct(input int count, input bit for_sender);
        case ((count * 5) / total_items)
            1:       return for_sender ? IDLE_HEAVY : 0;
            2:       return for_sender ? 0 : IDLE_HEAVY;
            3:       return IDLE_LIGHT;
            default: return 0;
        endcase
    endfunction

    task automatic stage_item(input logic kind, input logic [atp_pkg::IDX_W-1:0] idx,
                              input logic [atp_pkg::VAL_W-1:0] value, input logic is_cat,
                              input logic [atp_pkg::ERR_W-1:0] limit, input logic last);
        t_pruner_item it;
        it.kind        = kind;
        it.attr_index  = idx;
        it.value       = value;
        it.is_cat      = is_cat;
        it.error_limit = limit;
        it.last        = last;
        pending_items.push_back(it);
    endtask

    // Stimulus: a directed opening followed by random load-then-instance sequences.
    initial begin : stimulus
        logic [atp_pkg::VAL_W-1:0] ref_seen [atp_pkg::NUM_ATTRS];
        logic [atp_pkg::IDX_W-1:0] group[$];
        logic [atp_pkg::IDX_W-1:0] idx;
        logic [atp_pkg::VAL_W-1:0] val;
        logic [atp_pkg::ERR_W-1:0] lim;
        logic                      cat;
        int                        n_load;
        int                        n_inst;
        int                        n_vals;
        int                        delta;

        foreach (ref_seen[k]) ref_seen[k] = '0;

        // Largest possible numeric penalty against an all-ones limit: the error saturates
        // after two steps and the entry still survives because it only equals the limit.
        stage_item(atp_pkg::KIND_LOAD,  6'd0, 32'h7FFF_FFFF, 1'b0, atp_pkg::ERR_MAX, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd0, 32'h8000_0000, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd0, 32'h8000_0000, 1'b1, atp_pkg::ERR_MAX, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd0, 32'h8000_0000, 1'b0, '0, 1'b1);
        // Categorical entry with a zero limit: a match costs nothing, a one-bit mismatch
        // drops it, and a later value for the dead entry reports it as dropped with a zero error.
        stage_item(atp_pkg::KIND_LOAD,  6'd63, 32'h1234_5678, 1'b1, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd63, 32'h1234_5678, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd63, 32'h1234_5679, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd63, 32'hFFFF_FFFF, 1'b1, atp_pkg::ERR_MAX, 1'b1);
        // A value for an entry that was never loaded, closing an instance with no drop.
        stage_item(atp_pkg::KIND_APPLY, 6'd5, 32'h0000_0000, 1'b0, '0, 1'b1);
        // Reload over a live entry, with the end-of-instance mark on the load itself.
        stage_item(atp_pkg::KIND_LOAD,  6'd0, 32'h8000_0000, 1'b0, 48'h1_0000, 1'b1);
        stage_item(atp_pkg::KIND_APPLY, 6'd0, 32'h8001_0000, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd0, 32'h8000_0000, 1'b0, '0, 1'b1);
        // Truncation of the squared difference: one LSB apart costs nothing, 2^-8 apart
        // costs one LSB, which is already above a zero limit.
        stage_item(atp_pkg::KIND_LOAD,  6'd42, 32'h0000_0000, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd42, 32'h0000_0000, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd42, 32'h0000_0001, 1'b0, '0, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd42, 32'hFFFF_FF00, 1'b0, '0, 1'b1);
        stage_item(atp_pkg::KIND_LOAD,  6'd21, 32'hFFFF_FFFF, 1'b1, atp_pkg::ERR_MAX, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd21, 32'h0000_0000, 1'b1, atp_pkg::ERR_MAX, 1'b0);
        stage_item(atp_pkg::KIND_APPLY, 6'd21, 32'hFFFF_FFFF, 1'b0, '0, 1'b1);

        while (pending_items.size() < ITEM_COUNT) begin
            if ($urandom_range(9) < 8) begin
                // Load a small group of entries, then run a few instances over it.
                group.delete();
                n_load = $urandom_range(1, 8);
                for (int k = 0; k < n_load; k++) begin
                    idx = 6'($urandom_range(63));
                    cat = ($urandom_range(3) == 0);
                    val = $urandom;
                    case ($urandom_range(4))
                        0:       lim = '0;
                        1:       lim = atp_pkg::ERR_W'($urandom_range(0, 1 << 18));
                        2:       lim = atp_pkg::ERR_W'({$urandom, $urandom});
                        3:       lim = atp_pkg::ERR_MAX;
                        default: lim = atp_pkg::ERR_W'($urandom_range(1 << 16, 1 << 22));
                    endcase
                    ref_seen[idx] = val;
                    stage_item(atp_pkg::KIND_LOAD, idx, val, cat, lim,
                               $urandom_range(15) == 0);
                    group.push_back(idx);
                end
                n_inst = $urandom_range(1, 4);
                for (int m = 0; m < n_inst; m++) begin
                    n_vals = $urandom_range(1, group.size() + 2);
                    for (int v = 0; v < n_vals; v++) begin
                        if ($urandom_range(5) == 0) idx = 6'($urandom_range(63));
                        else idx = group[$urandom_range(group.size() - 1)];
                        case ($urandom_range(3))
                            0: val = ref_seen[idx];
                            1: begin
                                delta = $urandom_range(0, 1 << 17) - (1 << 16);
                                val = ref_seen[idx] + atp_pkg::VAL_W'(delta);
                            end
                            2: begin
                                delta = $urandom_range(0, 1 << 11) - (1 << 10);
                                val = ref_seen[idx] + atp_pkg::VAL_W'(delta);
                            end
                            default: val = $urandom;
                        endcase
                        // The load-only fields are ignored here, so they carry random bits.
                        stage_item(atp_pkg::KIND_APPLY, idx, val, 1'($urandom),
                                   atp_pkg::ERR_W'({$urandom, $urandom}), v == n_vals - 1);
                    end
                end
            end else begin
                // Noise: fully random items of either kind.
                n_vals = $urandom_range(1, 6);
                for (int k = 0; k < n_vals; k++) begin
                    stage_item(1'($urandom), 6'($urandom), $urandom, 1'($urandom),
                               atp_pkg::ERR_W'({$urandom, $urandom}), 1'($urandom));
                end
            end
        end
        total_items = pending_items.size();
    end

    // Driver: an offered item stays put until it is accepted; the next one is chosen at the
    // same edge, so valid only ever sees one assignment per edge. Prediction happens at the
    // edge of acceptance, which keeps the expected results in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(prune_step(offered));
                sent_count <= sent_count + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0
                        && $urandom_range(99) >= idle_pct(sent_count, 1'b1)) begin
                    offered = pending_items.pop_front();
                    i_kind           <= offered.kind;
                    i_attr_index     <= offered.attr_index;
                    i_value          <= offered.value;
                    i_is_categorical <= offered.is_cat;
                    i_error_limit    <= offered.error_limit;
                    i_last           <= offered.last;
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [atp_pkg::ERR_W-1:0] want,
                               input logic [atp_pkg::ERR_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: compares every accepted result with the oldest prediction, then decides
    // whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_pruner_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual entry %0d",
                             $time, o_entry_index);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("entry_index", atp_pkg::ERR_W'(want.entry_index),
                                atp_pkg::ERR_W'(o_entry_index));
                    check_field("alive", atp_pkg::ERR_W'(want.alive),
                                atp_pkg::ERR_W'(o_alive));
                    check_field("accumulated_error", want.accumulated_error,
                                o_accumulated_error);
                    check_field("survivors", atp_pkg::ERR_W'(want.survivors),
                                atp_pkg::ERR_W'(o_survivors));
                    check_field("shrank", atp_pkg::ERR_W'(want.shrank),
                                atp_pkg::ERR_W'(o_shrank));
                    check_field("last_res", atp_pkg::ERR_W'(want.last_res),
                                atp_pkg::ERR_W'(o_last_res));
                end
                recv_count <= recv_count + 1;
            end
            i_stall <= (hold_left != 0) || ($urandom_range(99) < idle_pct(recv_count, 1'b0));
        end
    end

    // One long hold-off early in the run, while the sender keeps offering items, so the
    // result register fills and the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && recv_count >= HOLD_OFF_AT) begin
            hold_left <= HOLD_OFF_LEN;
            hold_done <= 1'b1;
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ns: timeout after %0d quiet cycles", $time, QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // Reset, then wait on the falling edge (clear of the edge where queues change) until all
    // items are accepted and every prediction is matched, then let the pipeline drain.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
